// ===== hdl/polynomial_term_engine_assert.svh =====
// Assertion macros for the polynomial term engine.
`ifndef POLYNOMIAL_TERM_ENGINE_ASSERT_SVH
`define POLYNOMIAL_TERM_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PTE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PTE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PTE_ASSERT_IMPL(label, ante, cons)
`define PTE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/pte_pkg.sv =====
// ----------------------------------------------------------------------------
// pte_pkg
// Types, op codes and constants of the polynomial term engine.
// ----------------------------------------------------------------------------
package pte_pkg;
	localparam int MaxDegree = 63;
	localparam int NCoef = MaxDegree + 1;
	localparam int IdxW = $clog2(NCoef);
	localparam int CntW = $clog2(NCoef + 1);

	typedef enum logic [2:0] {
		OP_ADD_TERM  = 3'd0,
		OP_LOAD_TERM = 3'd1,
		OP_ADD       = 3'd2,
		OP_SUB       = 3'd3,
		OP_SCALE     = 3'd4,
		OP_MUL       = 3'd5,
		OP_CLEAR     = 3'd6,
		OP_QUERY     = 3'd7
	} op_t;

	// Command broadcast to every cell in one cycle.
	typedef struct packed {
		logic       rot;      // rotate both stores by one cell
		logic       acc_a;    // current += operand (sub: minus)
		logic       sub;
		logic       scl;      // current *= factor
		logic       clr_cur;
		logic       clr_opd;
		logic       clr_prd;
		logic       shift_p;  // product <= lower neighbor + cur * broadcast
		logic       ld_cur;   // current <= product
	} cell_cmd_t;
endpackage

// ===== hdl/polynomial_term_engine.sv =====
// ----------------------------------------------------------------------------
// polynomial_term_engine
// Coefficient stores as a row of cells driven by a small sequencer.
// ----------------------------------------------------------------------------
// channel | direction | fields
// in      | sink      | op, coef_in, power
// out     | source    | degree, coef_out, dropped
// Term, load term, add, subtract, scale, clear, query: an execute state, then a
// degree scan over every cell; the result is registered at the end of the scan.
// Multiply: Horner steps (overflow check on the word leaving the top cell),
// a turn state, then the scan. Reset clears all stores at once. The input
// stalls from its transfer until the result transfer; a stalled result holds
// the block.
// ----------------------------------------------------------------------------
module polynomial_term_engine
	import pte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic signed [31:0] coef_in,
	input  logic [5:0]  power,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [6:0]  degree,
	output logic signed [31:0] coef_out,
	output logic        dropped
);
	`include "polynomial_term_engine_assert.svh"

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EXEC = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_HIGH = 6'b001000,
		ST_SCAN = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	op_t op_q;
	logic [31:0] coef_q;
	logic [IdxW-1:0] pow_q;
	logic [CntW-1:0] cnt_q;
	logic lost_q, found_q;
	logic [IdxW-1:0] deg_q;
	logic [31:0] hold_q;
	cell_cmd_t cmd;
	logic [31:0] cur_w [NCoef];
	logic [31:0] opd_w [NCoef];
	logic [31:0] prd_w [NCoef];
	logic [31:0] bcast;
	logic [31:0] hi_acc;
	logic last;

	// Multiply in Horner form over the operand, top word first: each cycle the
	// operand row rotates up so the top cell holds the next lower word, and
	// every product cell takes its lower neighbor plus cur * that word. A word
	// leaving the top product cell is a finished term above the maximum degree.
	assign last = (cnt_q == CntW'(NCoef - 1));
	assign hi_acc = prd_w[NCoef-1];

	always_comb begin
		cmd = '0;
		bcast = coef_q;
		case (state_q)
			ST_EXEC: begin
				case (op_q)
					OP_ADD:   cmd.acc_a = 1'b1;
					OP_SUB:   begin cmd.acc_a = 1'b1; cmd.sub = 1'b1; end
					OP_SCALE: cmd.scl = 1'b1;
					OP_CLEAR: cmd.clr_cur = 1'b1;
					OP_MUL:   cmd.clr_prd = 1'b1;
					default:  ;
				endcase
			end
			ST_MUL: begin
				cmd.shift_p = 1'b1;
				bcast = opd_w[NCoef-1];
			end
			ST_SCAN: begin
				// drop the operand after add, subtract and multiply
				if (cnt_q == '0) begin
					if (op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL)
						cmd.clr_opd = 1'b1;
					if (op_q == OP_MUL) cmd.ld_cur = 1'b1;
				end
			end
			default: ;
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < NCoef; g++) begin : g_cell
			logic [31:0] cn, on, pn;
			if (g == 0) begin : g_low
				assign on = opd_w[NCoef-1];
				assign pn = 32'd0;
			end else begin : g_up
				assign on = opd_w[g-1];
				assign pn = prd_w[g-1];
			end
			assign cn = cur_w[(g + 1) % NCoef];
			// in multiply the operand word moves up by adding the difference
			pte_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.cmd(cmd),
				.hit(state_q == ST_EXEC && op_q == OP_ADD_TERM && pow_q == IdxW'(g)),
				.hit_opd((state_q == ST_EXEC && op_q == OP_LOAD_TERM
					&& pow_q == IdxW'(g)) || (state_q == ST_MUL)),
				.term((state_q == ST_MUL) ? (on - opd_w[g]) : coef_q),
				.bcast(bcast),
				.cur_nb(cn),
				.opd_nb(on),
				.prd_nb(pn),
				.cur(cur_w[g]),
				.opd(opd_w[g]),
				.prd(prd_w[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			lost_q    <= 1'b0;
			found_q   <= 1'b0;
			deg_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_EXEC;
					lost_q  <= 1'b0;
				end
				ST_EXEC: begin
					cnt_q   <= '0;
					state_q <= (op_q == OP_MUL) ? ST_MUL : ST_SCAN;
				end
				ST_MUL: begin
					// a product word leaving the top at step > 0 is a term above
					// the maximum degree
					if (cnt_q != '0 && hi_acc != 32'd0) lost_q <= 1'b1;
					if (last) begin
						cnt_q   <= '0;
						state_q <= ST_HIGH;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_HIGH: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cnt_q != '0 && cur_w[IdxW'(cnt_q - 1'b1)] != 32'd0) begin
						found_q <= 1'b1;
						deg_q   <= IdxW'(cnt_q - 1'b1);
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(NCoef)) begin
						state_q   <= ST_OUT;
						out_valid <= 1'b1;
					end
				end
				ST_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					found_q   <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q   <= op_t'(op);
			coef_q <= coef_in;
			pow_q  <= power;
		end
		if (state_q == ST_SCAN) hold_q <= cur_w[pow_q];
	end

	assign in_stall = (state_q != ST_IDLE);
	assign degree   = found_q ? {1'b0, deg_q} : -7'sd1;
	assign coef_out = hold_q;
	assign dropped  = lost_q & (op_q == OP_MUL);

	`PTE_ASSERT_IMPL(a_out_only_in_out, out_valid, state_q == ST_OUT)
	`PTE_ASSERT_NEXT(a_exec_after_accept, in_valid && !in_stall, state_q == ST_EXEC)
	`PTE_ASSERT_IMPL(a_drop_mul_only, out_valid && dropped, op_q == OP_MUL)
endmodule

// ===== hdl/pte_cell.sv =====
// ----------------------------------------------------------------------------
// pte_cell
// One coefficient slot: current, operand and product words.
// ----------------------------------------------------------------------------
module pte_cell
	import pte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cell_cmd_t   cmd,
	input  logic        hit,       // this cell is the addressed power
	input  logic        hit_opd,
	input  logic [31:0] term,
	input  logic [31:0] bcast,     // scale factor or operand word for multiply
	input  logic [31:0] cur_nb,    // neighbor words for rotate
	input  logic [31:0] opd_nb,
	input  logic [31:0] prd_nb,    // lower neighbor product for shift
	output logic [31:0] cur,
	output logic [31:0] opd,
	output logic [31:0] prd
);
	logic [31:0] cur_q, opd_q, prd_q;
	logic [31:0] prod;

	assign prod = cur_q * bcast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			opd_q <= '0;
			prd_q <= '0;
		end else begin
			if (cmd.clr_cur) cur_q <= '0;
			else if (cmd.ld_cur) cur_q <= prd_q;
			else if (cmd.rot) cur_q <= cur_nb;
			else if (cmd.scl) cur_q <= prod;
			else if (cmd.acc_a) cur_q <= cmd.sub ? cur_q - opd_q : cur_q + opd_q;
			else if (hit) cur_q <= cur_q + term;

			if (cmd.clr_opd) opd_q <= '0;
			else if (cmd.rot) opd_q <= opd_nb;
			else if (hit_opd) opd_q <= opd_q + term;

			if (cmd.clr_prd) prd_q <= '0;
			else if (cmd.shift_p) prd_q <= prd_nb + prod;
		end
	end

	assign cur = cur_q;
	assign opd = opd_q;
	assign prd = prd_q;
endmodule
